// File: rtl/dit_pkg.sv
// ----------------------------------------------------------------------------
// dit_pkg
// shared types and constants of the disjoint interval tracker
// ----------------------------------------------------------------------------
package dit_pkg;
	localparam int MaxIntervals = 32;
	localparam int ValueBits    = 16;
	localparam int CountBits    = $clog2(MaxIntervals + 1);

	typedef enum logic [2:0] {
		ST_NEW     = 3'd0,
		ST_UP      = 3'd1,
		ST_DOWN    = 3'd2,
		ST_JOIN    = 3'd3,
		ST_COVERED = 3'd4,
		ST_FULL    = 3'd5,
		ST_LIST    = 3'd6
	} status_t;

	localparam logic REQ_ADD  = 1'b0;
	localparam logic REQ_DUMP = 1'b1;

	typedef struct packed {
		logic                 req_type;
		logic [ValueBits-1:0] value;
	} req_t;

	typedef struct packed {
		logic [2:0]           status;
		logic [ValueBits-1:0] interval_start;
		logic [ValueBits-1:0] interval_end;
		logic [CountBits-1:0] interval_count;
		logic                 last;
	} rsp_t;
endpackage

// File: rtl/dit_ram.sv
// ----------------------------------------------------------------------------
// dit_ram
// generic single-port-write, single-port-read ram with registered read
// ----------------------------------------------------------------------------
module dit_ram #(
	parameter int Width = 16,
	parameter int Depth = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// File: rtl/disjoint_interval_tracker.sv
// ----------------------------------------------------------------------------
// disjoint_interval_tracker
// sorted table of disjoint integer intervals held in two rams
// ----------------------------------------------------------------------------
// Requests come in on req (valid/ready) and results go out on rsp
// (valid/ready), one request worked at a time. An add scans the table from
// the bottom, one entry at a time (ram read, compare), until it passes the
// value; a new interval then moves the entries above it up one place (ram
// read, ram write per entry), a join moves them down (S_NEXT_RD, S_MOVE_RD,
// S_MOVE_WR per entry). An add gives a single result, after the scan, any
// moves and the entry write; covered or full skip the moves and the write.
// A dump reads each entry (S_DUMP_RD, S_DUMP_OUT) and shows it, and reads
// each further entry only after the result before it is taken; an empty
// table gives one empty result on the cycle after the request. last marks
// the final result. Every result sits in an output register; when the
// receiver stalls the block waits with that result and takes no new request
// until it is gone, and it is ready again in the cycle after the final
// result is taken. Reset clears the interval count and the control
// registers but not the rams; ram contents need no clearing and the block
// is ready straight after reset.
// ----------------------------------------------------------------------------
module disjoint_interval_tracker #(
	parameter int MAX_INTERVALS = dit_pkg::MaxIntervals
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  dit_pkg::req_t  req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output dit_pkg::rsp_t  rsp
);
	import dit_pkg::*;

	localparam int VALUE_BITS = ValueBits;
	localparam int AW = $clog2(MAX_INTERVALS);
	localparam int CW = $clog2(MAX_INTERVALS + 1);
	localparam int LW = VALUE_BITS + 1;
	localparam int SW = LW + 1;

	typedef enum logic [3:0] {
		S_IDLE, S_SCAN_RD, S_SCAN_CHK, S_DECIDE, S_NEXT_RD, S_NEXT_CHK,
		S_MOVE_RD, S_MOVE_WR, S_FINAL, S_DUMP_RD, S_DUMP_OUT, S_OUT
	} state_t;

	state_t           state_q;
	logic [CW-1:0]    count_q;
	logic [CW-1:0]    idx_q;
	logic [CW-1:0]    mv_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [VALUE_BITS-1:0] ps_q;
	logic [LW-1:0]    pl_q;
	logic             has_p_q;
	logic             is_join_q;
	logic             dump_q;

	// ram ports
	logic                  we;
	logic [AW-1:0]         waddr, raddr;
	logic [VALUE_BITS-1:0] wstart, rstart;
	logic [LW-1:0]         wlen, rlen;

	// entry write in S_NEXT_CHK shares the port with the move writes
	logic                  fix_we;
	logic [AW-1:0]         fix_addr;
	logic                  ram_we;
	logic [AW-1:0]         ram_waddr;
	logic [VALUE_BITS-1:0] ram_wstart;
	logic [LW-1:0]         ram_wlen;

	dit_ram #(.Width(VALUE_BITS), .Depth(MAX_INTERVALS)) u_start (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wstart), .raddr(raddr),
		.rdata(rstart)
	);
	dit_ram #(.Width(LW), .Depth(MAX_INTERVALS)) u_len (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wlen), .raddr(raddr),
		.rdata(rlen)
	);

	logic [SW-1:0] p_end;     // start + length of entry below
	logic [SW-1:0] r_end;
	logic [SW-1:0] val_x;
	logic [VALUE_BITS-1:0] dump_end;

	assign p_end = SW'(ps_q) + SW'(pl_q);
	assign r_end = SW'(rstart) + SW'(rlen);
	assign val_x = SW'(val_q);
	assign dump_end = VALUE_BITS'(r_end - SW'(1));

	assign req_ready = (state_q == S_IDLE);

	// ram control, from registered state only
	always_comb begin
		we     = 1'b0;
		waddr  = idx_q[AW-1:0];
		raddr  = idx_q[AW-1:0];
		wstart = rstart;
		wlen   = rlen;
		case (state_q)
			S_MOVE_RD: begin
				raddr = mv_q[AW-1:0];
			end
			S_MOVE_WR: begin
				we = 1'b1;
				// join moves entries down, insert moves them up
				waddr = is_join_q ? AW'(mv_q - CW'(1)) : AW'(mv_q + CW'(1));
			end
			default: begin
			end
		endcase
	end

	assign fix_we   = (state_q == S_NEXT_CHK);
	assign fix_addr = has_p_q ? AW'(idx_q - CW'(1)) : idx_q[AW-1:0];

	always_comb begin
		ram_we     = we | fix_we;
		ram_waddr  = fix_we ? fix_addr : waddr;
		ram_wstart = fix_we ? ps_q : wstart;
		ram_wlen   = fix_we ? pl_q : wlen;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			rsp_valid <= 1'b0;
			idx_q     <= '0;
			mv_q      <= '0;
			val_q     <= '0;
			ps_q      <= '0;
			pl_q      <= '0;
			has_p_q   <= 1'b0;
			is_join_q <= 1'b0;
			dump_q    <= 1'b0;
			rsp       <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						idx_q   <= '0;
						has_p_q <= 1'b0;
						val_q   <= VALUE_BITS'(req.value);
						dump_q  <= (req.req_type == REQ_DUMP);
						if (req.req_type == REQ_DUMP) begin
							if (count_q == '0) begin
								rsp       <= '{ST_LIST, '0, '0, '0, 1'b1};
								rsp_valid <= 1'b1;
								state_q   <= S_OUT;
							end else begin
								state_q <= S_DUMP_RD;
							end
						end else begin
							state_q <= S_SCAN_RD;
						end
					end
				end
				S_SCAN_RD: begin
					state_q <= (idx_q < count_q) ? S_SCAN_CHK : S_DECIDE;
				end
				S_SCAN_CHK: begin
					if (rstart <= val_q) begin
						ps_q    <= rstart;
						pl_q    <= rlen;
						has_p_q <= 1'b1;
						idx_q   <= idx_q + CW'(1);
						state_q <= S_SCAN_RD;
					end else begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					// ram output still holds entry idx when idx < count
					rsp.interval_start <= '0;
					rsp.interval_end   <= '0;
					rsp.last           <= 1'b1;
					if (has_p_q && val_x < p_end) begin
						rsp.status <= ST_COVERED;
						state_q    <= S_FINAL;
					end else if (has_p_q && val_x == p_end) begin
						if (idx_q < count_q && val_x + SW'(1) == SW'(rstart)) begin
							// join: lower entry grows by 1 + upper length
							pl_q       <= LW'(SW'(pl_q) + SW'(1) + SW'(rlen));
							is_join_q  <= 1'b1;
							rsp.status <= ST_JOIN;
							mv_q       <= idx_q + CW'(1);
							state_q    <= S_NEXT_RD;
						end else begin
							pl_q       <= pl_q + LW'(1);
							is_join_q  <= 1'b0;
							rsp.status <= ST_UP;
							state_q    <= S_NEXT_RD;
							mv_q       <= count_q;
						end
					end else if (idx_q < count_q && val_x + SW'(1) == SW'(rstart)) begin
						ps_q       <= val_q;
						pl_q       <= rlen + LW'(1);
						is_join_q  <= 1'b0;
						has_p_q    <= 1'b0;
						rsp.status <= ST_DOWN;
						mv_q       <= count_q;
						state_q    <= S_NEXT_RD;
					end else if (count_q == CW'(MAX_INTERVALS)) begin
						rsp.status <= ST_FULL;
						state_q    <= S_FINAL;
					end else begin
						ps_q       <= val_q;
						pl_q       <= LW'(1);
						is_join_q  <= 1'b0;
						has_p_q    <= 1'b0;
						rsp.status <= ST_NEW;
						mv_q       <= count_q - CW'(1);
						state_q    <= (count_q == idx_q) ? S_NEXT_CHK : S_MOVE_RD;
						count_q    <= count_q + CW'(1);
					end
				end
				S_NEXT_RD: begin
					// up, down: single entry write; join: move upper entries down
					if (is_join_q && mv_q < count_q) begin
						state_q <= S_MOVE_RD;
					end else begin
						if (is_join_q) begin
							count_q <= count_q - CW'(1);
						end
						state_q <= S_NEXT_CHK;
					end
				end
				S_MOVE_RD: begin
					state_q <= S_MOVE_WR;
				end
				S_MOVE_WR: begin
					if (is_join_q) begin
						mv_q    <= mv_q + CW'(1);
						state_q <= S_NEXT_RD;
					end else if (mv_q == idx_q) begin
						state_q <= S_NEXT_CHK;
					end else begin
						mv_q    <= mv_q - CW'(1);
						state_q <= S_MOVE_RD;
					end
				end
				S_NEXT_CHK: begin
					// write the merged or new entry
					state_q <= S_FINAL;
				end
				S_FINAL: begin
					rsp.interval_count <= CountBits'(count_q);
					rsp_valid          <= 1'b1;
					state_q            <= S_OUT;
				end
				S_DUMP_RD: begin
					state_q <= S_DUMP_OUT;
				end
				S_DUMP_OUT: begin
					rsp       <= '{ST_LIST, rstart, dump_end, CountBits'(count_q),
						idx_q + CW'(1) == count_q};
					rsp_valid <= 1'b1;
					idx_q     <= idx_q + CW'(1);
					state_q   <= S_OUT;
				end
				S_OUT: begin
					if (rsp_ready) begin
						rsp_valid <= 1'b0;
						state_q   <= (dump_q && idx_q < count_q) ? S_DUMP_RD : S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule
